[rtl/ial_pkg.sv]
// Shared constants, codes and types for the indexed array list.
package ial_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned ADDR_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = 9;
  localparam int unsigned CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int unsigned DATA_W   = 32;

  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_REMOVE_AT  = 2'd1;
  localparam logic [1:0] REQ_REMOVE_VAL = 2'd2;
  localparam logic [1:0] REQ_FIND       = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ial_mem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              found;
    logic [ADDR_W-1:0] position;
    logic [CNT_W-1:0]  count;
  } ial_res_t;

endpackage

[rtl/indexed_array_list.sv]
// Indexed array list top level: request sequencer, entry memory, result register.
//
// Ordered list of up to 256 signed 32-bit values held in a single
// simple-dual-port RAM (one write, one registered read per cycle) plus a
// count. One request is worked at a time: insert at index (clamped to
// append, rejected with status 2 when full), remove at index (status 1 when
// out of range), remove first match and find (status 1, found 0 when
// absent). Every request gives exactly one result transfer carrying the
// count afterwards. Cost is set by the RAM walk, one entry per cycle:
// insert at i shifts entries i and up one place higher, remove at i
// shifts the entries above i one place lower, find walks from entry 0
// to the first match or the end, and remove by value runs the search
// and then the shift-down walk from the hit position.
// A new request is taken as soon as the previous one has left the
// sequencer, even while its result still waits on out_stall. The RAM needs
// no clearing pass: only entries below the count are ever read.
module indexed_array_list import ial_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_req_type,
  input  logic [8:0]               in_index,
  input  logic signed [31:0]       in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic                     out_found,
  output logic [7:0]               out_position,
  output logic [8:0]               out_count
);

  ial_mem_req_t      mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              idle;
  logic              res_valid;
  logic              res_take;
  ial_res_t          res;
  logic              in_fire;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        status_r;
  logic              found_r;
  logic [7:0]        position_r;
  logic [8:0]        count_r;

  // input transfer only while the sequencer is free
  assign in_stall = !idle;
  assign in_fire  = in_valid && idle;

  ial_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_req_type(in_req_type),
    .in_index   (in_index),
    .in_value   (in_value),
    .idle       (idle),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  ial_ram u_ram (
    .clk  (clk),
    .req  (mem_req),
    .rdata(mem_rdata)
  );

  // result register: loads when empty or being drained this cycle
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status_r   <= res.status;
      found_r    <= res.found;
      position_r <= 8'(res.position);
      count_r    <= 9'(res.count);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_found    = found_r;
  assign out_position = position_r;
  assign out_count    = count_r;

  // a match always reports done
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_DONE)
    else $error("found result without done status");

  // misses and non-search requests report position zero
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == 8'd0)
    else $error("nonzero position without a match");

  // full rejection only when the list is at capacity
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_count == 9'(CAPACITY))
    else $error("full status below capacity");

  // count never leaves its range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a taken request always leaves the sequencer busy
  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !idle)
    else $error("sequencer idle right after a request");

endmodule

[rtl/ial_ram.sv]
// Entry storage: one write port, one read port, registered read data.
module ial_ram import ial_pkg::*; (
  input  logic              clk,
  input  ial_mem_req_t      req,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ial_ctrl.sv]
// Request sequencer: shift, search and count update over the entry memory.
module ial_ctrl import ial_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        in_req_type,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [DATA_W-1:0] in_value,
  output logic              idle,
  output ial_mem_req_t      mem_req,
  input  logic [DATA_W-1:0] mem_rdata,
  output logic              res_valid,
  input  logic              res_take,
  output ial_res_t          res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_DEL  = 5'b00100,
    S_SRCH = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [1:0]        req_r, req_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;

  logic [CMP_W-1:0]  idx_ext, cnt_ext, idx_clamp;

  assign idx_ext   = CMP_W'(in_index);
  assign cnt_ext   = CMP_W'(cnt_r);
  assign idx_clamp = (idx_ext > cnt_ext) ? cnt_ext : idx_ext;

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    pend_addr_nxt = pend_addr_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    req_nxt       = req_r;
    status_nxt    = status_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = pend_addr_r;
    mem_req.wdata = mem_rdata;
    mem_req.raddr = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt    = in_req_type;
          val_nxt    = in_value;
          status_nxt = ST_DONE;
          found_nxt  = 1'b0;
          pos_nxt    = '0;
          pend_nxt   = 1'b0;
          last_nxt   = ADDR_W'(cnt_r - CNT_W'(1));
          case (in_req_type)
            REQ_INSERT: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                idx_nxt   = ADDR_W'(idx_clamp);
                iss_nxt   = (idx_clamp < cnt_ext);
                ptr_nxt   = ADDR_W'(cnt_r - CNT_W'(1));
                last_nxt  = ADDR_W'(idx_clamp);
                state_nxt = S_INS;
              end
            end
            REQ_REMOVE_AT: begin
              if (idx_ext >= cnt_ext) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                iss_nxt   = (idx_ext + CMP_W'(1) < cnt_ext);
                ptr_nxt   = ADDR_W'(idx_ext + CMP_W'(1));
                state_nxt = S_DEL;
              end
            end
            default: begin
              if (cnt_r == '0) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                iss_nxt   = 1'b1;
                ptr_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
          endcase
        end
      end

      S_INS: begin
        // read i-1, write it to i in the next cycle, walking downward
        pend_nxt      = iss_r;
        pend_addr_nxt = ptr_r;
        if (iss_r) begin
          if (ptr_r == last_r) iss_nxt = 1'b0;
          else                 ptr_nxt = ptr_r - ADDR_W'(1);
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_addr_r + ADDR_W'(1);
        end else if (!iss_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = idx_r;
          mem_req.wdata = val_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
          state_nxt     = S_RESP;
        end
      end

      S_DEL: begin
        // read i+1, write it to i in the next cycle, walking upward
        pend_nxt      = iss_r;
        pend_addr_nxt = ptr_r;
        if (iss_r) begin
          if (ptr_r == last_r) iss_nxt = 1'b0;
          else                 ptr_nxt = ptr_r + ADDR_W'(1);
        end
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_addr_r - ADDR_W'(1);
        end else if (!iss_r) begin
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end

      S_SRCH: begin
        pend_nxt      = iss_r;
        pend_addr_nxt = ptr_r;
        if (iss_r) begin
          if (ptr_r == last_r) iss_nxt = 1'b0;
          else                 ptr_nxt = ptr_r + ADDR_W'(1);
        end
        if (pend_r && (mem_rdata == val_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = pend_addr_r;
          if (req_r == REQ_REMOVE_VAL) begin
            // hand over to the shift-down walk from the hit position
            iss_nxt   = (CNT_W'(pend_addr_r) + CNT_W'(1) < cnt_r);
            ptr_nxt   = pend_addr_r + ADDR_W'(1);
            pend_nxt  = 1'b0;
            state_nxt = S_DEL;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (!pend_r && !iss_r) begin
          status_nxt = ST_MISS;
          state_nxt  = S_RESP;
        end
      end

      S_RESP: begin
        if (res_take) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_r   <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    last_r      <= last_nxt;
    pend_addr_r <= pend_addr_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    req_r       <= req_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
  end

  assign idle         = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_RESP);
  assign res.status   = status_r;
  assign res.found    = found_r;
  assign res.position = pos_r;
  assign res.count    = cnt_r;

endmodule
